@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define BDLP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define BDLP_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define BDLP_ASSERT(label, clk, rst_n, prop)
`define BDLP_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ sv/bdlp_pkg.sv @@
package bdlp_pkg;

  // Field and register widths.
  localparam int unsigned DEB_W      = 8;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NUM_THRESH = 4;

  // Register reset values.
  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd50;
  localparam logic [ACT_W-1:0] ACTIVE_RST   = 3'd4;

  // Event codes on the result channel.
  typedef enum logic [1:0] {
    EV_SHORT      = 2'd0,
    EV_LONG_START = 2'd1,
    EV_LONG_END   = 2'd2
  } ev_code_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_MS  = 3'd0,
    REG_ACTIVE       = 3'd1,
    REG_LONG_PRESS_0 = 3'd2,
    REG_LONG_PRESS_1 = 3'd3,
    REG_LONG_PRESS_2 = 3'd4,
    REG_LONG_PRESS_3 = 3'd5
  } cfg_reg_e;

  // What one lane reports for the current tick.
  typedef struct packed {
    logic     valid;
    ev_code_e code;
  } lane_ev_t;

endpackage

@@ sv/button_debounce_long_press_unit.sv @@
// Button debouncer with long-press detection.
// Input channel: one word per millisecond tick on pin_levels_i, one active-low
// level per button, handshaked with in_valid_i / in_stall_o. Every button has a
// lane of its own that debounces its level and times the long press.
// Result channel: one word per event on button_index_o, event_code_o and last_o,
// handshaked with out_valid_o / out_stall_i. Events of one tick come out in
// ascending button order; last_o marks the final event of the tick. A tick
// without events gives no word.
// A taken tick's events are registered as pending, then move one at a time into
// the output register of the single result port; the next tick is taken in the
// cycle in which the last event of the previous one enters the output register,
// and a tick without events does not hold back the next one.
// When the receiver stalls, the output word holds and pending events wait,
// and in_stall_o rises once any event is still waiting.
// Reset: every button released and idle, debounce 50 ticks, four buttons in
// use, long-press thresholds zero. The user must write registers through cfg_we_i,
// cfg_idx_i and cfg_wdata_i only while no events are outstanding; the block does not enforce this.
module button_debounce_long_press_unit #(
  parameter int unsigned LANE_COUNT = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bdlp_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [LANE_COUNT-1:0]                pin_levels_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [((LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1)-1:0] button_index_o,
  output logic [1:0]                           event_code_o,
  output logic                                 last_o
);

  localparam int unsigned IdxW = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;

  logic [bdlp_pkg::DEB_W-1:0]  debounce_ms_q;
  logic [bdlp_pkg::ACT_W-1:0]  active_q;
  logic [bdlp_pkg::HOLD_W-1:0] long_press_q [bdlp_pkg::NUM_THRESH];

  logic                       busy;
  logic                       accept;
  logic [LANE_COUNT-1:0]      lane_en;
  bdlp_pkg::lane_ev_t         lane_ev [LANE_COUNT];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q <= bdlp_pkg::DEBOUNCE_RST;
      active_q      <= bdlp_pkg::ACTIVE_RST;
      for (int k = 0; k < bdlp_pkg::NUM_THRESH; k++) begin
        long_press_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (bdlp_pkg::cfg_reg_e'(cfg_idx_i))
        bdlp_pkg::REG_DEBOUNCE_MS:  debounce_ms_q   <= cfg_wdata_i[bdlp_pkg::DEB_W-1:0];
        bdlp_pkg::REG_ACTIVE:       active_q        <= cfg_wdata_i[bdlp_pkg::ACT_W-1:0];
        bdlp_pkg::REG_LONG_PRESS_0: long_press_q[0] <= cfg_wdata_i;
        bdlp_pkg::REG_LONG_PRESS_1: long_press_q[1] <= cfg_wdata_i;
        bdlp_pkg::REG_LONG_PRESS_2: long_press_q[2] <= cfg_wdata_i;
        bdlp_pkg::REG_LONG_PRESS_3: long_press_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A tick is taken once the previous tick's events have all left the queue.
  assign accept     = in_valid_i && !busy;
  assign in_stall_o = busy;

  // One lane per button; lanes at or above the active count stay frozen.
  for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
    logic [bdlp_pkg::HOLD_W-1:0] thr;

    if (g < bdlp_pkg::NUM_THRESH) begin : g_thr
      assign thr = long_press_q[g];
    end else begin : g_no_thr
      assign thr = '0;
    end

    assign lane_en[g] = accept && ({1'b0, active_q} > 4'(g));

    bdlp_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (lane_en[g]),
      .level_i       (pin_levels_i[g]),
      .debounce_ms_i (debounce_ms_q),
      .threshold_i   (thr),
      .ev_o          (lane_ev[g])
    );
  end

  // Serialize the lane events onto the result channel.
  bdlp_merge #(
    .LANE_COUNT (LANE_COUNT),
    .IDX_W      (IdxW)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .lane_ev_i      (lane_ev),
    .busy_o         (busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .button_index_o (button_index_o),
    .event_code_o   (event_code_o),
    .last_o         (last_o)
  );

endmodule

@@ sv/bdlp_lane.sv @@
`include "assert_macros.svh"

module bdlp_lane (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       level_i,
  input  logic [bdlp_pkg::DEB_W-1:0]  debounce_ms_i,
  input  logic [bdlp_pkg::HOLD_W-1:0] threshold_i,
  output bdlp_pkg::lane_ev_t         ev_o
);

  logic                       prev_q, prev_d;
  logic [bdlp_pkg::DEB_W-1:0]  deb_cnt_q, deb_cnt_d;
  logic                       deb_run_q, deb_run_d;
  logic                       pressed_q, pressed_d;
  logic [bdlp_pkg::HOLD_W-1:0] hold_cnt_q, hold_cnt_d;
  logic                       hold_run_q, hold_run_d;

  logic                       change;
  logic [bdlp_pkg::DEB_W-1:0]  deb_dec;
  logic                       deb_done;
  logic                       take_press;
  logic                       take_release;
  logic [bdlp_pkg::HOLD_W-1:0] hold_dec;
  logic                       hold_tick;
  bdlp_pkg::lane_ev_t         ev;

  // Decode what this tick does to the lane.
  assign change       = (level_i != prev_q);
  assign deb_dec      = deb_cnt_q - bdlp_pkg::DEB_W'(1);
  assign deb_done     = !change && deb_run_q && (deb_dec == '0);
  assign take_press   = deb_done && !level_i && !pressed_q;
  assign take_release = deb_done && level_i && pressed_q;
  assign hold_dec     = hold_cnt_q - bdlp_pkg::HOLD_W'(1);
  // A release that stops the countdown comes first and skips the hold check.
  assign hold_tick    = hold_run_q && !take_release;

  // Next state and event: debounce check first, then the long-press check.
  always_comb begin
    prev_d     = level_i;
    deb_cnt_d  = deb_cnt_q;
    deb_run_d  = deb_run_q;
    pressed_d  = pressed_q;
    hold_cnt_d = hold_cnt_q;
    hold_run_d = hold_run_q;
    ev.valid   = 1'b0;
    ev.code    = bdlp_pkg::EV_SHORT;

    if (change) begin
      deb_cnt_d = (debounce_ms_i == '0) ? bdlp_pkg::DEB_W'(1) : debounce_ms_i;
      deb_run_d = 1'b1;
    end else if (deb_run_q) begin
      deb_cnt_d = deb_dec;
      if (deb_dec == '0) begin
        deb_run_d = 1'b0;
      end
    end

    if (take_press) begin
      pressed_d = 1'b1;
      if (threshold_i != '0) begin
        hold_cnt_d = threshold_i;
        hold_run_d = 1'b1;
      end
    end

    if (take_release) begin
      pressed_d = 1'b0;
      ev.valid  = 1'b1;
      if (hold_run_q) begin
        hold_run_d = 1'b0;
        ev.code    = bdlp_pkg::EV_SHORT;
      end else begin
        ev.code    = bdlp_pkg::EV_LONG_END;
      end
    end

    if (hold_tick) begin
      hold_cnt_d = hold_dec;
      if (hold_dec == '0) begin
        hold_run_d = 1'b0;
        if (!level_i) begin
          ev.valid = 1'b1;
          ev.code  = bdlp_pkg::EV_LONG_START;
        end
      end
    end
  end

  // Only an enabled lane reports.
  always_comb begin
    ev_o       = ev;
    ev_o.valid = ev.valid && en_i;
  end

  // Lane state advances once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= 1'b1;
      deb_cnt_q  <= '0;
      deb_run_q  <= 1'b0;
      pressed_q  <= 1'b0;
      hold_cnt_q <= '0;
      hold_run_q <= 1'b0;
    end else if (en_i) begin
      prev_q     <= prev_d;
      deb_cnt_q  <= deb_cnt_d;
      deb_run_q  <= deb_run_d;
      pressed_q  <= pressed_d;
      hold_cnt_q <= hold_cnt_d;
      hold_run_q <= hold_run_d;
    end
  end

  `BDLP_ASSERT(a_hold_only_when_pressed, clk_i, rst_ni, hold_run_q |-> pressed_q)
  `BDLP_ASSERT_NEVER(a_deb_cnt_live, clk_i, rst_ni, deb_run_q && (deb_cnt_q == '0))
  `BDLP_ASSERT(a_idle_lane_frozen, clk_i, rst_ni,
               !en_i |=> $stable(pressed_q) && $stable(hold_cnt_q) && $stable(deb_cnt_q))

endmodule

@@ sv/bdlp_merge.sv @@
`include "assert_macros.svh"

module bdlp_merge #(
  parameter int unsigned LANE_COUNT = 4,
  parameter int unsigned IDX_W      = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  bdlp_pkg::lane_ev_t       lane_ev_i [LANE_COUNT],
  output logic                     busy_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [IDX_W-1:0]         button_index_o,
  output logic [1:0]               event_code_o,
  output logic                     last_o
);

  logic [LANE_COUNT-1:0] pend_q, pend_d;
  bdlp_pkg::ev_code_e    code_q [LANE_COUNT];
  logic [LANE_COUNT-1:0] ev_mask;
  logic [LANE_COUNT-1:0] sel_oh;
  logic [IDX_W-1:0]      sel_idx;
  logic [LANE_COUNT-1:0] rest;
  logic [LANE_COUNT-1:0] pend_after;
  logic                  load;

  logic                  out_valid_q, out_valid_d;
  logic [IDX_W-1:0]      out_idx_q;
  bdlp_pkg::ev_code_e    out_code_q;
  logic                  out_last_q;

  // Gather the lanes that reported this tick.
  always_comb begin
    for (int i = 0; i < LANE_COUNT; i++) begin
      ev_mask[i] = lane_ev_i[i].valid;
    end
  end

  // Pick the lowest pending lane.
  always_comb begin
    sel_idx = '0;
    sel_oh  = '0;
    for (int i = LANE_COUNT - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel_idx    = IDX_W'(i);
        sel_oh     = '0;
        sel_oh[i]  = 1'b1;
      end
    end
  end

  // A pending word moves into the output register when that register frees up.
  assign rest       = pend_q & ~sel_oh;
  assign load       = (|pend_q) && (!out_valid_q || !out_stall_i);
  assign pend_after = load ? rest : pend_q;
  assign busy_o     = |pend_after;
  assign pend_d     = accept_i ? ev_mask : pend_after;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Event codes of the accepted tick.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int i = 0; i < LANE_COUNT; i++) begin
        code_q[i] <= lane_ev_i[i].code;
      end
    end
  end

  // Output word.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_idx_q  <= sel_idx;
      out_code_q <= code_q[sel_idx];
      out_last_q <= ~|rest;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign button_index_o = out_idx_q;
  assign event_code_o   = out_code_q;
  assign last_o         = out_last_q;

  `BDLP_ASSERT_NEVER(a_accept_drained, clk_i, rst_ni, accept_i && (|pend_after))
  `BDLP_ASSERT(a_events_queued, clk_i, rst_ni, accept_i && (|ev_mask) |=> (|pend_q))
  `BDLP_ASSERT(a_more_after_non_last, clk_i, rst_ni, load && (|rest) |=> (|pend_q))

endmodule

@@ dv/tb_button_debounce_long_press_unit.sv @@
`timescale 1ns / 1ps

module tb_button_debounce_long_press_unit;

  localparam int unsigned NB = 4;
  localparam int unsigned IDX_W = 2;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  // Indexes past the last register; writes to them must change nothing.
  localparam logic [bdlp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [bdlp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

  typedef struct {
    logic [NB-1:0] levels;
    int unsigned   gap;
  } tick_word_t;

  typedef struct {
    logic [IDX_W-1:0]   lane;
    bdlp_pkg::ev_code_e code;
    logic               last;
  } btn_ev_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [bdlp_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [bdlp_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [NB-1:0]                   pin_levels_i = '1;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [IDX_W-1:0]                button_index_o;
  logic [1:0]                      event_code_o;
  logic                            last_o;

  button_debounce_long_press_unit #(.LANE_COUNT(NB)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pin_levels_i   (pin_levels_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .button_index_o (button_index_o),
    .event_code_o   (event_code_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies and lane state of the predictor.
  logic [bdlp_pkg::DEB_W-1:0]  cfg_debounce;
  logic [bdlp_pkg::ACT_W-1:0]  cfg_active;
  logic [bdlp_pkg::HOLD_W-1:0] cfg_hold_ms [bdlp_pkg::NUM_THRESH];
  logic [NB-1:0]               last_levels;
  logic [bdlp_pkg::DEB_W-1:0]  settle_left [NB];
  logic [NB-1:0]               settle_busy;
  logic [NB-1:0]               held_flags;
  logic [bdlp_pkg::HOLD_W-1:0] hold_left [NB];
  logic [NB-1:0]               hold_busy;

  tick_word_t    pending_ticks [$];
  btn_ev_t       expected_events [$];
  tick_word_t    cur_tick;
  logic          tick_loaded = 1'b0;
  logic          tick_fire_q = 1'b0;
  logic          word_fire_q = 1'b0;
  int unsigned   gap_max = 0;
  int unsigned   stall_max = 0;
  int unsigned   stall_left = 0;
  int unsigned   hold_off_requests = 0;
  int unsigned   hold_off_served = 0;
  int unsigned   hold_off_left = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  logic [NB-1:0] gen_levels = '1;

  task automatic reset_model();
    cfg_debounce = bdlp_pkg::DEBOUNCE_RST;
    cfg_active   = bdlp_pkg::ACTIVE_RST;
    for (int k = 0; k < bdlp_pkg::NUM_THRESH; k++) cfg_hold_ms[k] = '0;
    for (int k = 0; k < NB; k++) begin
      settle_left[k] = '0;
      hold_left[k]   = '0;
    end
    last_levels = '1;
    settle_busy = '0;
    held_flags  = '0;
    hold_busy   = '0;
  endtask

  // Works out the events one tick causes, in ascending lane order.
  task automatic predict_button_events(input logic [NB-1:0] levels);
    btn_ev_t            tick_events [$];
    btn_ev_t            ev;
    int                 lane_count;
    logic               hold_was;
    logic               fire;
    bdlp_pkg::ev_code_e code;
    lane_count = (cfg_active > NB) ? NB : cfg_active;
    code = bdlp_pkg::EV_SHORT;
    for (int i = 0; i < lane_count; i++) begin
      hold_was = hold_busy[i];
      fire = 1'b0;
      // Debounce first: any change restarts the countdown.
      if (levels[i] != last_levels[i]) begin
        settle_left[i] = (cfg_debounce == 0) ? 8'd1 : cfg_debounce;
        settle_busy[i] = 1'b1;
      end else if (settle_busy[i]) begin
        settle_left[i] = settle_left[i] - 8'd1;
        if (settle_left[i] == 0) begin
          settle_busy[i] = 1'b0;
          if (!levels[i]) begin
            if (!held_flags[i]) begin
              held_flags[i] = 1'b1;
              if (cfg_hold_ms[i] != 0) begin
                hold_left[i] = cfg_hold_ms[i];
                hold_busy[i] = 1'b1;
              end
            end
          end else if (held_flags[i]) begin
            held_flags[i] = 1'b0;
            fire = 1'b1;
            if (hold_busy[i]) begin
              hold_busy[i] = 1'b0;
              code = bdlp_pkg::EV_SHORT;
            end else begin
              code = bdlp_pkg::EV_LONG_END;
            end
          end
        end
      end
      last_levels[i] = levels[i];
      // Long-press countdown, only one that was already running.
      if (hold_was && hold_busy[i]) begin
        hold_left[i] = hold_left[i] - 16'd1;
        if (hold_left[i] == 0) begin
          hold_busy[i] = 1'b0;
          if (!levels[i]) begin
            fire = 1'b1;
            code = bdlp_pkg::EV_LONG_START;
          end
        end
      end
      if (fire) begin
        ev.lane = IDX_W'(i);
        ev.code = code;
        ev.last = 1'b0;
        tick_events.push_back(ev);
      end
    end
    foreach (tick_events[k]) begin
      ev = tick_events[k];
      ev.last = (k == tick_events.size() - 1);
      expected_events.push_back(ev);
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_event();
    btn_ev_t ev;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("unexpected event word: button %0d code %0d last %0d",
                                button_index_o, event_code_o, last_o));
    end else begin
      ev = expected_events.pop_front();
      if (button_index_o !== ev.lane)
        report_mismatch($sformatf("button index %0d, expected %0d", button_index_o, ev.lane));
      if (event_code_o !== ev.code)
        report_mismatch($sformatf("event code %0d on button %0d, expected %0d",
                                  event_code_o, ev.lane, ev.code));
      if (last_o !== ev.last)
        report_mismatch($sformatf("last %0d on button %0d, expected %0d",
                                  last_o, ev.lane, ev.last));
    end
  endtask

  task automatic push_tick(input logic [NB-1:0] levels);
    tick_word_t t;
    t.levels = levels;
    t.gap = $urandom_range(0, gap_max);
    pending_ticks.push_back(t);
  endtask

  // Holds of random length on random lane patterns, with one-tick glitches.
  task automatic queue_press_pattern(input int unsigned n_ticks, input int unsigned span);
    int unsigned   pushed;
    int unsigned   run;
    logic [NB-1:0] flip;
    pushed = 0;
    while (pushed < n_ticks) begin
      flip = NB'($urandom_range(0, 15));
      if ($urandom_range(0, 7) == 0) begin
        push_tick(gen_levels ^ (flip | 4'b0001));
        pushed++;
      end else begin
        gen_levels = gen_levels ^ flip;
        run = $urandom_range(1, span);
        repeat (run) push_tick(gen_levels);
        pushed += run;
      end
    end
  endtask

  // One register write; the predictor copy changes with it.
  task automatic write_reg(input logic [bdlp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdlp_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bdlp_pkg::REG_DEBOUNCE_MS:  cfg_debounce = data[bdlp_pkg::DEB_W-1:0];
      bdlp_pkg::REG_ACTIVE:       cfg_active = data[bdlp_pkg::ACT_W-1:0];
      bdlp_pkg::REG_LONG_PRESS_0,
      bdlp_pkg::REG_LONG_PRESS_1,
      bdlp_pkg::REG_LONG_PRESS_2,
      bdlp_pkg::REG_LONG_PRESS_3:
        cfg_hold_ms[2'(idx - bdlp_pkg::REG_LONG_PRESS_0)] = data[bdlp_pkg::HOLD_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Waits until every word is taken and every event is back, then lets the block settle.
  task automatic wait_idle();
    while (pending_ticks.size() != 0 || tick_loaded || in_valid_i ||
           expected_events.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Sample both handshakes at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      tick_fire_q <= in_valid_i && !in_stall_o;
      word_fire_q <= out_valid_o && !out_stall_i;
      if (out_valid_o && !out_stall_i) check_event();
      if (in_valid_i && !in_stall_o) predict_button_events(pin_levels_i);
    end else begin
      tick_fire_q <= 1'b0;
      word_fire_q <= 1'b0;
    end
  end

  // Input driver: each word waits its own gap, then stays up until taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || tick_fire_q) begin
      if (!tick_loaded && pending_ticks.size() != 0) begin
        cur_tick = pending_ticks.pop_front();
        tick_loaded = 1'b1;
      end
      if (tick_loaded && cur_tick.gap == 0) begin
        in_valid_i   <= 1'b1;
        pin_levels_i <= cur_tick.levels;
        tick_loaded = 1'b0;
      end else begin
        in_valid_i <= 1'b0;
        if (tick_loaded) cur_tick.gap = cur_tick.gap - 1;
      end
    end
  end

  // Receiver: a random stall after each event word, plus long hold-offs on request.
  always @(negedge clk_i) begin
    if (hold_off_requests != hold_off_served) begin
      hold_off_served = hold_off_requests;
      hold_off_left = HOLD_OFF_CYCLES;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (word_fire_q) stall_left = $urandom_range(0, stall_max);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [15:0] noise;
    logic [7:0]  deb_val;
    logic [2:0]  act_val;
    logic [15:0] thr;
    int unsigned max_thr;
    int unsigned span;
    int unsigned random_ticks;
    reset_model();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: short debounce, each kind of threshold, four events in one tick,
    // and a release on the very tick the long-press countdown would expire.
    gap_max = 10;
    stall_max = 10;
    write_reg(bdlp_pkg::REG_DEBOUNCE_MS, 16'd2);
    write_reg(bdlp_pkg::REG_LONG_PRESS_0, 16'd3);
    write_reg(bdlp_pkg::REG_LONG_PRESS_2, 16'hFFFF);
    write_reg(bdlp_pkg::REG_LONG_PRESS_3, 16'd1);
    write_reg(REG_UNMAPPED_A, 16'hFFFF);
    noise = 16'($urandom);
    write_reg(REG_UNMAPPED_B, noise);
    repeat (6) push_tick(4'b0000);
    repeat (3) push_tick(4'b1111);
    repeat (3) push_tick(4'b1110);
    repeat (3) push_tick(4'b1111);
    repeat (3) push_tick(4'b1011);
    wait_idle();

    // Threshold rewritten while button 2 counts, no lanes in use, zero debounce,
    // then a lane count above the number of buttons.
    write_reg(bdlp_pkg::REG_LONG_PRESS_2, 16'd2);
    write_reg(bdlp_pkg::REG_ACTIVE, 16'd0);
    write_reg(bdlp_pkg::REG_DEBOUNCE_MS, 16'd0);
    push_tick(4'b0101);
    wait_idle();
    write_reg(bdlp_pkg::REG_ACTIVE, 16'd7);
    repeat (2) push_tick(4'b1111);
    wait_idle();

    // Long debounce and long threshold on a single lane; the other lanes carry noise.
    gap_max = 0;
    stall_max = 0;
    write_reg(bdlp_pkg::REG_DEBOUNCE_MS, 16'd40);
    write_reg(bdlp_pkg::REG_ACTIVE, 16'd1);
    write_reg(bdlp_pkg::REG_LONG_PRESS_0, 16'd30);
    for (int k = 0; k < 72; k++) begin
      noise = 16'($urandom);
      push_tick({noise[NB-1:1], 1'b0});
    end
    for (int k = 0; k < 41; k++) begin
      noise = 16'($urandom);
      push_tick({noise[NB-1:1], 1'b1});
    end
    wait_idle();

    // Receiver holds off while the sender keeps offering event-rich ticks.
    write_reg(bdlp_pkg::REG_DEBOUNCE_MS, 16'd1);
    write_reg(bdlp_pkg::REG_ACTIVE, 16'd4);
    write_reg(bdlp_pkg::REG_LONG_PRESS_0, 16'd2);
    write_reg(bdlp_pkg::REG_LONG_PRESS_1, 16'd3);
    write_reg(bdlp_pkg::REG_LONG_PRESS_2, 16'd4);
    write_reg(bdlp_pkg::REG_LONG_PRESS_3, 16'd5);
    hold_off_requests++;
    for (int k = 0; k < 40; k++) begin
      noise = 16'($urandom);
      push_tick(noise[NB-1:0]);
    end
    wait_idle();

    // Random phases, each with its own settings and idling.
    random_ticks = 0;
    while (random_ticks < 80) begin
      deb_val = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
      noise = 16'($urandom);
      write_reg(bdlp_pkg::REG_DEBOUNCE_MS, {noise[15:8], deb_val});
      act_val = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      noise = 16'($urandom);
      write_reg(bdlp_pkg::REG_ACTIVE, {noise[15:3], act_val});
      max_thr = 0;
      for (int k = 0; k < bdlp_pkg::NUM_THRESH; k++) begin
        thr = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
        if (thr > max_thr) max_thr = thr;
        write_reg(bdlp_pkg::CFG_IDX_W'(bdlp_pkg::REG_LONG_PRESS_0 + k), thr);
      end
      span = ((deb_val == 0) ? 1 : deb_val) + max_thr + 3;
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      queue_press_pattern(40, span);
      random_ticks += 40;
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
